/* rtl/core/rgbdith_pkg.sv */
package rgbdith_pkg;

  // Default line buffer depth (widest supported row)
  localparam int DEF_MAX_WIDTH = 4096;

  // Error word: four 3-bit channel errors, red 2..0, green 5..3, blue 8..6, alpha 11..9
  localparam int CHAN_ERR_W = 3;
  localparam int ERR_WORD_W = 4 * CHAN_ERR_W;

  // Configuration register indexes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef logic [ERR_WORD_W-1:0] err_word_t;

  typedef struct packed {
    logic [3:0]            nibble;     // kept top nibble
    logic [CHAN_ERR_W-1:0] to_right;   // 7/16 share
    logic [CHAN_ERR_W-1:0] done_left;  // finished error for the lower-left pixel
    logic [CHAN_ERR_W-1:0] to_below;   // 5/16 share, start of the lower pixel's error
  } chan_result_t;

  // One channel: add carried errors, saturate, split into nibble and spread error
  function automatic chan_result_t dither_chan(input logic [7:0]            px,
                                               input logic [CHAN_ERR_W-1:0] err_above,
                                               input logic [CHAN_ERR_W-1:0] err_left,
                                               input logic [CHAN_ERR_W-1:0] part_left);
    logic [8:0]   sum;
    logic [7:0]   sat;
    logic [3:0]   e;
    logic [6:0]   e7;
    logic [5:0]   e3;
    logic [6:0]   e5;
    logic [2:0]   dl;
    chan_result_t r;
    sum = {1'b0, px} + {6'd0, err_above} + {6'd0, err_left};
    sat = sum[8] ? 8'hff : sum[7:0];
    e   = sat[3:0];
    e7  = 7'({e, 3'b000} - {3'd0, e});
    e3  = 6'({1'b0, e, 1'b0} + {2'b00, e});
    e5  = 7'({1'b0, e, 2'b00} + {3'b000, e});
    dl  = 3'(part_left + {1'b0, e3[5:4]});
    r.nibble    = sat[7:4];
    r.to_right  = e7[6:4];
    r.done_left = dl;
    r.to_below  = e5[6:4];
    return r;
  endfunction

endpackage

/* rtl/core/rgba4444_error_diffusion_dither_unit.sv */
// RGBA8888 to RGBA4444 converter with Floyd-Steinberg error diffusion. Pixels
// enter in raster order, one per clock while out_stall is low, and each gives
// one packed word through the input register, then the output register; the
// rate holds because the line buffer has a read port and a write port, each
// used once per pixel. Frame width and height come from the write port and
// take effect at once, restarting the frame at its top-left pixel; write them
// only while no pixel is in flight. Widths, taken from write_data[12:0], above
// MAX_WIDTH are treated as MAX_WIDTH, and zero width or height as one. The line
// buffer needs no clearing after reset: the top row of a frame never reads it.
module rgba4444_error_diffusion_dither_unit #(
  parameter int MAX_WIDTH = rgbdith_pkg::DEF_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        write_enable,
  input  logic        write_index,
  input  logic [15:0] write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  input  logic [7:0]  alpha_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] packed_pixel
);
  import rgbdith_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);

  // Frame geometry, held as last column / last row index
  logic [XW-1:0] col_last;
  logic [15:0]   row_last;

  // Position of the next pixel to arrive
  logic [XW-1:0] column_count;
  logic [15:0]   row_count;

  // Carried errors
  err_word_t right_carry;
  err_word_t pending_below_left;
  err_word_t edge_err;          // lower-row error of the last column

  // Stage 1: pixel waiting for its line buffer word
  logic          s1_valid;
  logic [31:0]   s1_px;
  logic [XW-1:0] s1_x;
  logic          s1_first;
  logic          s1_last;
  logic          s1_top;
  logic          s1_bottom;
  logic          fwd_hit;
  err_word_t     fwd_data;

  logic          accept;
  logic          adv;
  logic          pos_first;
  logic          pos_last;
  logic          pos_top;
  logic          pos_bottom;

  logic          wr_en;
  logic [XW-1:0] wr_addr;
  err_word_t     mem_q;
  err_word_t     below_w;
  err_word_t     rc_w;
  err_word_t     pbl_w;
  err_word_t     new_right;
  err_word_t     done_left;
  err_word_t     new_pbl;
  logic [15:0]   packed_next;
  chan_result_t  res [4];

  // Handshake: stage 1 moves on when the output register is free or being taken
  assign adv      = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !adv;
  assign accept   = in_valid && !in_stall;

  assign pos_first  = (column_count == '0);
  assign pos_last   = (column_count == col_last);
  assign pos_top    = (row_count == 16'd0);
  assign pos_bottom = (row_count == row_last);

  // Finished lower-left error goes to the line buffer unless on the bottom row
  assign wr_en   = adv && !s1_first && !s1_bottom;
  assign wr_addr = s1_x - 1'b1;

  rgbdith_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (done_left),
    .rd_en   (accept),
    .rd_addr (column_count),
    .rd_data (mem_q)
  );

  // Configuration and position tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      col_last     <= '0;
      row_last     <= 16'd0;
      column_count <= '0;
      row_count    <= 16'd0;
    end else if (write_enable) begin
      column_count <= '0;
      row_count    <= 16'd0;
      unique case (write_index)
        REG_IMAGE_WIDTH: begin
          if (32'(write_data[12:0]) > MAX_WIDTH) begin
            col_last <= XW'(MAX_WIDTH - 1);
          end else if (write_data[12:0] == 13'd0) begin
            col_last <= '0;
          end else begin
            col_last <= XW'(write_data[12:0] - 13'd1);
          end
        end
        REG_IMAGE_HEIGHT: begin
          row_last <= (write_data == 16'd0) ? 16'd0 : write_data - 16'd1;
        end
        default: begin
          row_last <= row_last;
        end
      endcase
    end else if (accept) begin
      if (pos_last) begin
        column_count <= '0;
        row_count    <= pos_bottom ? 16'd0 : row_count + 16'd1;
      end else begin
        column_count <= column_count + 1'b1;
      end
    end
  end

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  // Stage 1 payload; forward a line buffer write that lands on the edge of the read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px     <= {red_in, green_in, blue_in, alpha_in};
      s1_x      <= column_count;
      s1_first  <= pos_first;
      s1_last   <= pos_last;
      s1_top    <= pos_top;
      s1_bottom <= pos_bottom;
      fwd_hit   <= wr_en && (wr_addr == column_count);
      fwd_data  <= done_left;
    end
  end

  // Error pushed down from the row above
  always_comb begin
    if (s1_top) begin
      below_w = '0;
    end else if (s1_last) begin
      below_w = edge_err;
    end else if (fwd_hit) begin
      below_w = fwd_data;
    end else begin
      below_w = mem_q;
    end
  end

  assign rc_w  = s1_first ? '0 : right_carry;
  assign pbl_w = s1_first ? '0 : pending_below_left;

  // Per-channel dither; channel 0 is red in the error word
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      res[c] = dither_chan(s1_px[31-8*c -: 8],
                           below_w[CHAN_ERR_W*c +: CHAN_ERR_W],
                           rc_w[CHAN_ERR_W*c +: CHAN_ERR_W],
                           pbl_w[CHAN_ERR_W*c +: CHAN_ERR_W]);
      new_right[CHAN_ERR_W*c +: CHAN_ERR_W] = res[c].to_right;
      done_left[CHAN_ERR_W*c +: CHAN_ERR_W] = res[c].done_left;
      new_pbl[CHAN_ERR_W*c +: CHAN_ERR_W]   = res[c].to_below;
      packed_next[15-4*c -: 4]              = res[c].nibble;
    end
  end

  // Carried error registers; the 1/16 lower-right share of a nibble is always zero
  always_ff @(posedge clk) begin
    if (rst || write_enable) begin
      right_carry        <= '0;
      pending_below_left <= '0;
    end else if (adv) begin
      right_carry        <= s1_last ? '0 : new_right;
      pending_below_left <= new_pbl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_last && !s1_bottom) begin
      edge_err <= new_pbl;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      packed_pixel <= packed_next;
    end
  end

endmodule

/* rtl/core/rgbdith_line_mem.sv */
module rgbdith_line_mem #(
  parameter int DEPTH = rgbdith_pkg::DEF_MAX_WIDTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  rgbdith_pkg::err_word_t      wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output rgbdith_pkg::err_word_t      rd_data
);
  import rgbdith_pkg::*;

  err_word_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
